// ===== sv/tnu_pkg.sv =====
// Shared constants for the triangle normal unit.
// No dependencies; the interfaces, the top level and the scoreboard refer to it by scoped name.
package tnu_pkg;

    localparam int COORD_BITS     = 16;
    localparam int UNIT_FRAC_BITS = 14;
    localparam int OUT_BITS       = 34;

endpackage

// ===== sv/tnu_ifs.sv =====
// Valid/ready channel interfaces of the triangle normal unit.
// Depends on tnu_pkg for default widths.
interface tnu_vert_if #(
    parameter int COORD_BITS = tnu_pkg::COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p1_z;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p2_z;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic signed [COORD_BITS-1:0] p3_z;
    logic                         normalize;

    modport source (output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                    p3_x, p3_y, p3_z, normalize, input ready);
    modport sink (input valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  p3_x, p3_y, p3_z, normalize, output ready);
endinterface

interface tnu_norm_if;
    logic                                valid;
    logic                                ready;
    logic signed [tnu_pkg::OUT_BITS-1:0] normal_x;
    logic signed [tnu_pkg::OUT_BITS-1:0] normal_y;
    logic signed [tnu_pkg::OUT_BITS-1:0] normal_z;
    logic                                degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== sv/triangle_normal_unit.sv =====
// Top level of the triangle normal unit: cross product, length, unit scaling.
// Depends on tnu_pkg, the interfaces in tnu_ifs.sv and tnu_isqrt.
//
// Usage: each beat on vert carries three vertices and a normalize flag; each
// beat on norm carries the face normal n = (p1-p2) x (p2-p3) and a degenerate
// flag. With normalize low the normal is the exact integer cross product;
// with it high each component is n * 2^2F / isqrt(|n|^2 * 2^2F), truncated and
// clamped to +-2^F (Q1.F, F = UNIT_FRAC_BITS). A zero cross product gives
// zeros and degenerate high either way.
// Throughput: one beat per cycle, sustained while the receiver is ready. An
// accepted input beat passes the input stages, then the square root, which
// resolves one root bit per stage over the root width RW = (4*COORD_BITS + 6
// + 2*F) / 2, then the divider, which resolves one quotient bit per stage,
// and then the output register. The whole pipeline advances together: when
// the output beat is held by a receiver that is not ready, every stage and
// the input hold too, and no beat is lost or repeated. Reset clears all valid
// bits; no beat is in flight after it and nothing needs to be primed.
module triangle_normal_unit #(
    parameter int COORD_BITS     = tnu_pkg::COORD_BITS,
    parameter int UNIT_FRAC_BITS = tnu_pkg::UNIT_FRAC_BITS
) (
    input logic          clk,
    input logic          rst_n,
    tnu_vert_if.sink     vert,
    tnu_norm_if.source   norm
);
    localparam int CB     = COORD_BITS;
    localparam int F      = UNIT_FRAC_BITS;
    localparam int DW     = CB + 1;
    localparam int PW     = 2 * DW;
    localparam int NW     = PW + 1;
    localparam int MW     = NW - 1;
    localparam int SQW    = 2 * MW;
    localparam int SW     = SQW + 2;
    localparam int XW     = SW + 2 * F;
    localparam int RW     = XW / 2;
    localparam int NUMW   = MW + 2 * F;
    localparam int QW     = F + 1;
    localparam int CW     = ((NUMW > RW + F) ? NUMW : RW + F) + 1;
    localparam int OW     = tnu_pkg::OUT_BITS;
    localparam int SIDE_W = 3 * NW + 2;
    localparam logic [QW-1:0] UNIT = QW'(1) << F;

    logic en;

    // Stage 1: edge vectors.
    logic                 v1_reg;
    logic signed [DW-1:0] a1_reg [3];
    logic signed [DW-1:0] b1_reg [3];
    logic                 nrm1_reg;
    // Stage 2: partial products.
    logic                 v2_reg;
    logic signed [PW-1:0] p2_reg [6];
    logic                 nrm2_reg;
    // Stage 3: cross product.
    logic                 v3_reg;
    logic signed [NW-1:0] n3_reg [3];
    logic signed [NW-1:0] n3_next [3];
    logic                 nrm3_reg;
    logic                 z3_reg;
    // Stage 4: squared magnitudes.
    logic                 v4_reg;
    logic [SQW-1:0]       sq4_reg [3];
    logic signed [NW-1:0] n4_reg [3];
    logic                 nrm4_reg;
    logic                 z4_reg;
    logic [MW-1:0]        mag3 [3];
    // Stage 5: squared length, scaled.
    logic                 v5_reg;
    logic [XW-1:0]        x5_reg;
    logic [SIDE_W-1:0]    side5_reg;
    logic [SW-1:0]        sum4;

    assign en         = !norm.valid || norm.ready;
    assign vert.ready = en;

    always_comb
    begin
        n3_next[0] = NW'(p2_reg[0]) - NW'(p2_reg[1]);
        n3_next[1] = NW'(p2_reg[2]) - NW'(p2_reg[3]);
        n3_next[2] = NW'(p2_reg[4]) - NW'(p2_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            mag3[i] = n3_reg[i][NW-1] ? MW'(-n3_reg[i]) : MW'(n3_reg[i]);
        end
        sum4 = SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vert.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg[0] <= DW'(vert.p1_x) - DW'(vert.p2_x);
            a1_reg[1] <= DW'(vert.p1_y) - DW'(vert.p2_y);
            a1_reg[2] <= DW'(vert.p1_z) - DW'(vert.p2_z);
            b1_reg[0] <= DW'(vert.p2_x) - DW'(vert.p3_x);
            b1_reg[1] <= DW'(vert.p2_y) - DW'(vert.p3_y);
            b1_reg[2] <= DW'(vert.p2_z) - DW'(vert.p3_z);
            nrm1_reg  <= vert.normalize;

            p2_reg[0] <= a1_reg[1] * b1_reg[2];
            p2_reg[1] <= a1_reg[2] * b1_reg[1];
            p2_reg[2] <= a1_reg[2] * b1_reg[0];
            p2_reg[3] <= a1_reg[0] * b1_reg[2];
            p2_reg[4] <= a1_reg[0] * b1_reg[1];
            p2_reg[5] <= a1_reg[1] * b1_reg[0];
            nrm2_reg  <= nrm1_reg;

            n3_reg   <= n3_next;
            z3_reg   <= (n3_next[0] == '0) && (n3_next[1] == '0) && (n3_next[2] == '0);
            nrm3_reg <= nrm2_reg;

            for (int i = 0; i < 3; i++)
            begin
                sq4_reg[i] <= SQW'(mag3[i]) * SQW'(mag3[i]);
            end
            n4_reg   <= n3_reg;
            nrm4_reg <= nrm3_reg;
            z4_reg   <= z3_reg;

            x5_reg    <= {sum4, {(2*F){1'b0}}};
            side5_reg <= {n4_reg[0], n4_reg[1], n4_reg[2], nrm4_reg, z4_reg};
        end
    end

    logic              iv;
    logic [RW-1:0]     iroot;
    logic [SIDE_W-1:0] iside;

    tnu_isqrt #(
        .XW     (XW),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .x         (x5_reg),
        .side_in   (side5_reg),
        .out_valid (iv),
        .root      (iroot),
        .side_out  (iside)
    );

    // Divider: restoring steps from quotient bit F down to bit 0. The
    // quotient never exceeds 2^F because the root is at least |n_i| * 2^F.
    logic [2:0][NUMW-1:0] d_rem  [F+2];
    logic [2:0][QW-1:0]   d_q    [F+2];
    logic [RW-1:0]        d_len  [F+2];
    logic [SIDE_W-1:0]    d_side [F+2];
    logic                 d_v    [F+2];
    logic signed [NW-1:0] in_n   [3];

    assign in_n[0] = iside[SIDE_W-1 -: NW];
    assign in_n[1] = iside[SIDE_W-1-NW -: NW];
    assign in_n[2] = iside[NW+1 -: NW];

    for (genvar c = 0; c < 3; c++) begin : g_num
        logic [MW-1:0] mg;
        assign mg          = in_n[c][NW-1] ? MW'(-in_n[c]) : MW'(in_n[c]);
        assign d_rem[0][c] = {mg, {(2*F){1'b0}}};
        assign d_q[0][c]   = '0;
    end
    assign d_len[0]  = iroot;
    assign d_side[0] = iside;
    assign d_v[0]    = iv;

    for (genvar t = 0; t <= F; t++) begin : g_div
        localparam int K = F - t;
        logic [2:0][NUMW-1:0] rem_reg, rem_next;
        logic [2:0][QW-1:0]   q_reg, q_next;
        logic [RW-1:0]        len_reg;
        logic [SIDE_W-1:0]    side_reg;
        logic                 v_reg;
        logic [CW-1:0]        dv;
        logic [CW-1:0]        ext [3];

        always_comb
        begin
            dv = CW'(d_len[t]) << K;
            for (int c = 0; c < 3; c++)
            begin
                ext[c] = CW'(d_rem[t][c]);
                if (ext[c] >= dv)
                begin
                    rem_next[c] = NUMW'(ext[c] - dv);
                    q_next[c]   = {d_q[t][c][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = d_rem[t][c];
                    q_next[c]   = {d_q[t][c][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= d_v[t];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                len_reg  <= d_len[t];
                side_reg <= d_side[t];
            end
        end

        assign d_rem[t+1]  = rem_reg;
        assign d_q[t+1]    = q_reg;
        assign d_len[t+1]  = len_reg;
        assign d_side[t+1] = side_reg;
        assign d_v[t+1]    = v_reg;
    end

    // Output stage: choose raw, unit or zero and apply the sign.
    logic signed [NW-1:0] f_n [3];
    logic                 f_nrm;
    logic                 f_zero;
    logic [QW-1:0]        f_qm [3];
    logic signed [OW-1:0] f_val [3];

    logic                 out_v_reg;
    logic signed [OW-1:0] out_n_reg [3];
    logic                 out_deg_reg;

    assign f_n[0] = d_side[F+1][SIDE_W-1 -: NW];
    assign f_n[1] = d_side[F+1][SIDE_W-1-NW -: NW];
    assign f_n[2] = d_side[F+1][NW+1 -: NW];
    assign f_nrm  = d_side[F+1][1];
    assign f_zero = d_side[F+1][0];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            f_qm[c] = (d_q[F+1][c] > UNIT) ? UNIT : d_q[F+1][c];
            if (f_zero)
            begin
                f_val[c] = '0;
            end
            else if (f_nrm)
            begin
                f_val[c] = f_n[c][NW-1] ? -OW'(f_qm[c]) : OW'(f_qm[c]);
            end
            else
            begin
                f_val[c] = OW'(f_n[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            out_v_reg <= d_v[F+1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_n_reg   <= f_val;
            out_deg_reg <= f_zero;
        end
    end

    assign norm.valid      = out_v_reg;
    assign norm.normal_x   = out_n_reg[0];
    assign norm.normal_y   = out_n_reg[1];
    assign norm.normal_z   = out_n_reg[2];
    assign norm.degenerate = out_deg_reg;

    // A degenerate beat never carries a nonzero component.
    assert property (@(posedge clk) disable iff (!rst_n)
        norm.valid && norm.degenerate |->
            (norm.normal_x == '0) && (norm.normal_y == '0) && (norm.normal_z == '0))
        else $error("degenerate beat with nonzero normal");

    // The divider's quotient stays within unity for a real triangle.
    assert property (@(posedge clk) disable iff (!rst_n)
        d_v[F+1] && !f_zero && f_nrm |->
            (d_q[F+1][0] <= UNIT) && (d_q[F+1][1] <= UNIT) && (d_q[F+1][2] <= UNIT))
        else $error("unit quotient above one");

    // An accepted input beat enters the first stage on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        vert.valid && vert.ready |=> v1_reg)
        else $error("accepted beat lost at stage one");

    // While the pipeline is stalled the output beat stays valid and its x component and degenerate flag do not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_n_reg[0]) && $stable(out_deg_reg) && norm.valid)
        else $error("output changed during stall");

endmodule

// ===== sv/tnu_isqrt.sv =====
// Pipelined integer square root, one root bit per register stage.
// Carries an opaque sideband word alongside; no package dependencies.
module tnu_isqrt #(
    parameter int XW     = 98,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [XW-1:0]       x,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic [XW/2-1:0]     root,
    output logic [SIDE_W-1:0]   side_out
);
    localparam int RW = XW / 2;

    logic [RW+1:0]     s_rem  [RW+1];
    logic [RW-1:0]     s_root [RW+1];
    logic [XW-1:0]     s_x    [RW+1];
    logic [SIDE_W-1:0] s_side [RW+1];
    logic              s_v    [RW+1];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_x[0]    = x;
    assign s_side[0] = side_in;
    assign s_v[0]    = in_valid;

    for (genvar j = 0; j < RW; j++) begin : g_step
        logic [RW+1:0]     rem_reg, rem_next;
        logic [RW-1:0]     root_reg, root_next;
        logic [XW-1:0]     x_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              v_reg;
        logic [RW+3:0]     rs;
        logic [RW+3:0]     tr;

        // Bring down the next two radicand bits and try root*4+1.
        always_comb
        begin
            rs = {s_rem[j], s_x[j][XW-1 -: 2]};
            tr = {2'b00, s_root[j], 2'b01};
            if (rs >= tr)
            begin
                rem_next  = (RW+2)'(rs - tr);
                root_next = {s_root[j][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rs[RW+1:0];
                root_next = {s_root[j][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= s_v[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                x_reg    <= {s_x[j][XW-3:0], 2'b00};
                side_reg <= s_side[j];
            end
        end

        assign s_rem[j+1]  = rem_reg;
        assign s_root[j+1] = root_reg;
        assign s_x[j+1]    = x_reg;
        assign s_side[j+1] = side_reg;
        assign s_v[j+1]    = v_reg;
    end

    assign out_valid = s_v[RW];
    assign root      = s_root[RW];
    assign side_out  = s_side[RW];

endmodule

// ===== test/tnu_scoreboard.sv =====
// Scoreboard for the triangle normal unit testbench: predicts each face normal
// and checks output beats in order. Depends on tnu_pkg.
`timescale 1ns / 1ps

class tnu_scoreboard;

    typedef struct {
        logic signed [tnu_pkg::OUT_BITS-1:0] nx;
        logic signed [tnu_pkg::OUT_BITS-1:0] ny;
        logic signed [tnu_pkg::OUT_BITS-1:0] nz;
        logic                                degen;
    } normal_t;

    normal_t pending_normals[$];
    int      error_count;

    function new();
        pending_normals = {};
        error_count = 0;
    endfunction

    // Scales one component to unit length, truncating toward zero and clamping.
    function automatic logic signed [63:0] unit_scale(logic signed [63:0] comp,
                                                      logic [127:0] len);
        logic [127:0] num;
        logic [127:0] quot;
        logic [127:0] lim;
        lim = 128'd1 << tnu_pkg::UNIT_FRAC_BITS;
        num = (comp < 0) ? 128'(-comp) : 128'(comp);
        num = num << (2 * tnu_pkg::UNIT_FRAC_BITS);
        quot = num / len;
        if (quot > lim)
            quot = lim;
        return (comp < 0) ? -$signed(64'(quot)) : $signed(64'(quot));
    endfunction

    function automatic logic [127:0] int_sqrt(logic [127:0] x);
        logic [127:0] root;
        logic [127:0] rem;
        logic [127:0] trial;
        root = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = (rem << 2) | ((x >> (2 * i)) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function void note_triangle(logic signed [15:0] p[9], logic norm_en);
        logic signed [63:0] a[3];
        logic signed [63:0] b[3];
        logic signed [63:0] n[3];
        logic [127:0]       sum_sq;
        logic [127:0]       len;
        normal_t            exp_n;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 64'(p[i]) - 64'(p[3 + i]);
            b[i] = 64'(p[3 + i]) - 64'(p[6 + i]);
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        exp_n.degen = (n[0] == 0 && n[1] == 0 && n[2] == 0);
        if (!exp_n.degen && norm_en)
        begin
            sum_sq = 0;
            for (int i = 0; i < 3; i++)
                sum_sq += 128'(n[i] < 0 ? -n[i] : n[i]) * 128'(n[i] < 0 ? -n[i] : n[i]);
            len = int_sqrt(sum_sq << (2 * tnu_pkg::UNIT_FRAC_BITS));
            for (int i = 0; i < 3; i++)
                n[i] = unit_scale(n[i], len);
        end
        exp_n.nx = n[0][tnu_pkg::OUT_BITS-1:0];
        exp_n.ny = n[1][tnu_pkg::OUT_BITS-1:0];
        exp_n.nz = n[2][tnu_pkg::OUT_BITS-1:0];
        pending_normals.push_back(exp_n);
    endfunction

    function void check_normal(normal_t got);
        normal_t exp_n;
        if (pending_normals.size() == 0)
        begin
            $error("output beat with no triangle pending");
            error_count++;
            return;
        end
        exp_n = pending_normals.pop_front();
        if (got.nx !== exp_n.nx)
        begin
            $error("normal_x expected %0d got %0d", exp_n.nx, got.nx);
            error_count++;
        end
        if (got.ny !== exp_n.ny)
        begin
            $error("normal_y expected %0d got %0d", exp_n.ny, got.ny);
            error_count++;
        end
        if (got.nz !== exp_n.nz)
        begin
            $error("normal_z expected %0d got %0d", exp_n.nz, got.nz);
            error_count++;
        end
        if (got.degen !== exp_n.degen)
        begin
            $error("degenerate expected %0b got %0b", exp_n.degen, got.degen);
            error_count++;
        end
    endfunction

endclass

// ===== test/tb_triangle_normal_unit.sv =====
// Top of the triangle normal unit testbench: drives triangles, stalls the
// output side and checks every normal. Depends on tnu_ifs, tnu_scoreboard (and through it tnu_pkg) and the DUT.
`timescale 1ns / 1ps

module tb_triangle_normal_unit;

    localparam int RANDOM_BEATS = 900;
    localparam int IDLE_LIMIT   = 5000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sending_done = 1'b0;
    logic long_stall = 1'b0;
    int   idle_cycles = 0;

    tnu_vert_if vert ();
    tnu_norm_if norm ();

    tnu_scoreboard normals = new();

    triangle_normal_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vert  (vert.sink),
        .norm  (norm.source)
    );

    always #5 clk = ~clk;

    initial
    begin
        vert.valid = 1'b0;
        {vert.p1_x, vert.p1_y, vert.p1_z, vert.p2_x, vert.p2_y, vert.p2_z,
         vert.p3_x, vert.p3_y, vert.p3_z, vert.normalize} = '0;
        norm.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offers one triangle and waits until it is accepted. Valid stays high
    // after the beat so that a following triangle with no gap goes straight on.
    task automatic send_triangle(logic signed [15:0] p[9], logic norm_en, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            vert.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vert.valid     <= 1'b1;
        vert.p1_x      <= p[0];
        vert.p1_y      <= p[1];
        vert.p1_z      <= p[2];
        vert.p2_x      <= p[3];
        vert.p2_y      <= p[4];
        vert.p2_z      <= p[5];
        vert.p3_x      <= p[6];
        vert.p3_y      <= p[7];
        vert.p3_z      <= p[8];
        vert.normalize <= norm_en;
        @(posedge clk);
        while (!vert.ready)
            @(posedge clk);
        normals.note_triangle(p, norm_en);
    endtask

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom());
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    initial
    begin
        logic signed [15:0] p[9];
        bit                 burst;
        int                 mode;
        @(posedge rst_n);
        @(posedge clk);
        // Directed: extremes, collinear and coincident points, unit clamps.
        for (int k = 0; k < 20; k++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                case (k % 10)
                    0: p[i] = 16'sh0000;
                    1: p[i] = 16'sh7FFF;
                    2: p[i] = (i % 2 == 0) ? 16'sh7FFF : 16'sh8000;
                    3: p[i] = (i < 3) ? 16'sh7FFF : ((i < 6) ? 16'sh8000 : 16'sh7FFF);
                    4: p[i] = 16'(i * 100);
                    5: p[i] = (i == 0 || i == 7) ? 16'sh7FFF : 16'sh8000;
                    6: p[i] = (i == 0) ? 16'sd1 : ((i == 7) ? 16'sd1 : 16'sd0);
                    7: p[i] = (i == 0) ? 16'sh8000 : ((i == 7) ? 16'sh7FFF : 16'sd0);
                    8: p[i] = 16'(i % 3) * 16'sd5;
                    default: p[i] = (i == 4 || i == 6) ? 16'sh8000 : 16'sd3;
                endcase
            end
            send_triangle(p, k >= 10, 1'b0);
        end
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord(mode);
            // Occasionally make the triangle degenerate by repeating a vertex.
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++)
                    p[3 + i] = p[i];
            burst = (k >= 300 && k < 400) || (k % 97 < 15);
            send_triangle(p, 1'($urandom()), burst);
        end
        vert.valid <= 1'b0;
        sending_done <= 1'b1;
    end

    // Output side: random stalls, one long hold-off while input keeps coming.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_stall && normals.pending_normals.size() > 40 && idle_cycles == 0)
            begin
                long_stall = 1'b1;
                norm.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0)
                wait_cycles = 0;
            if (wait_cycles != 0)
            begin
                norm.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            norm.ready <= 1'b1;
            @(posedge clk);
            while (!norm.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && norm.valid && norm.ready)
            normals.check_normal('{norm.normal_x, norm.normal_y, norm.normal_z,
                                   norm.degenerate});
    end

    always @(posedge clk)
    begin
        if (rst_n && !((vert.valid && vert.ready) || (norm.valid && norm.ready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sending_done && normals.pending_normals.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (normals.error_count == 0)
                    $display("*** PASSED ***");
                else
                    $display("*** FAILED ***");
                $finish;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $error("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
